// ----- rtl/core/ugqa_pkg.sv -----
// Package for the user/group quota accounting unit: types and codes.
`default_nettype none

package ugqa_pkg;

    localparam int unsigned ID_W   = 10;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned OP_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ACCOUNT     = 4'd0,
        OP_CHECK       = 4'd1,
        OP_SET_ULIMIT  = 4'd2,
        OP_SET_GLIMIT  = 4'd3,
        OP_CLEAR_USAGE = 4'd4,
        OP_SET_UUSAGE  = 4'd5,
        OP_SET_GUSAGE  = 4'd6,
        OP_SET_TUSAGE  = 4'd7,
        OP_READ_USER   = 4'd8,
        OP_READ_GROUP  = 4'd9,
        OP_READ_TOTAL  = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ID_W-1:0]          user_id;
        logic [ID_W-1:0]          group_id;
        logic signed [WORD_W-1:0] delta;
        logic [WORD_W-1:0]        value;
    } t_in;

    typedef struct packed {
        logic              write_ok;
        logic [WORD_W-1:0] usage;
        logic [WORD_W-1:0] limit_out;
    } t_out;

    // One table row: limit word and usage word of one id.
    typedef struct packed {
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] usage;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    function automatic logic within_limit(input logic [WORD_W-1:0] used,
                                          input logic [WORD_W-1:0] req,
                                          input logic [WORD_W-1:0] lim);
        logic [WORD_W-1:0] sum;
        sum = used + req;
        return (lim == '0) || (sum <= lim);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ugqa_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ugqa_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/user_group_quota_accounting_unit.sv -----
// Top level of the user/group quota accounting unit.
`default_nettype none

// Keeps a total usage counter and per-user and per-group usage/limit words in
// two RAMs of 2^ID_BITS rows (limit and usage side by side). In an ordinary
// transaction the row is read in the accept cycle and the result is formed and
// written back in ST_EXEC once the registered read data returns and the output
// register is free. Clear usage adds a read-modify-write sweep over all rows
// before the next transaction is taken. After reset a clearing pass over all
// 2^ID_BITS rows zeroes both RAMs; no transaction is accepted until it ends,
// though total_limit may be written at any time.
module user_group_quota_accounting_unit #(
    parameter int unsigned ID_BITS = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire ugqa_pkg::t_in          i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output ugqa_pkg::t_out              o_out_data,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [ugqa_pkg::WORD_W-1:0] i_cfg_wr_data
);

    import ugqa_pkg::*;

    localparam int unsigned DEPTH  = 1 << ID_BITS;
    localparam int unsigned ID_EXT = (ID_BITS > ID_W) ? ID_BITS : ID_W;

    function automatic logic [ID_BITS-1:0] to_index(input logic [ID_W-1:0] id);
        logic [ID_EXT-1:0] ext;
        ext = ID_EXT'(id);
        return ext[ID_BITS-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [ID_BITS:0]    r_cnt;
    logic                r_wr_pend;
    logic [ID_BITS-1:0]  r_wr_addr;
    t_in                 r_item;
    logic [WORD_W-1:0]   r_total_usage, n_total_usage;
    logic [WORD_W-1:0]   r_total_limit;
    logic                r_out_valid;
    t_out                r_out_data, n_out_data;

    logic                out_free;
    logic                out_load;
    logic                rd_en;
    logic [ID_BITS-1:0]  u_rd_addr, g_rd_addr;
    logic                u_we, g_we;
    logic [ID_BITS-1:0]  u_wr_addr, g_wr_addr;
    t_entry              u_wr_data, g_wr_data;
    t_entry              u_rd_data, g_rd_data;
    t_entry              n_ue, n_ge;
    logic                exec_u_we, exec_g_we;

    assign out_free = !r_out_valid || !i_out_stall;

    // Result and write-back of the transaction held in r_item
    always_comb begin
        n_ue          = u_rd_data;
        n_ge          = g_rd_data;
        exec_u_we     = 1'b0;
        exec_g_we     = 1'b0;
        n_total_usage = r_total_usage;
        n_out_data    = '0;
        case (t_op'(r_item.op))
            OP_ACCOUNT: begin
                n_total_usage = r_total_usage + r_item.delta;
                n_ue.usage    = u_rd_data.usage + r_item.delta;
                n_ge.usage    = g_rd_data.usage + r_item.delta;
                exec_u_we     = 1'b1;
                exec_g_we     = 1'b1;
            end
            OP_CHECK: begin
                n_out_data.write_ok =
                    within_limit(r_total_usage, r_item.value, r_total_limit) &&
                    within_limit(u_rd_data.usage, r_item.value, u_rd_data.limit) &&
                    within_limit(g_rd_data.usage, r_item.value, g_rd_data.limit);
            end
            OP_SET_ULIMIT: begin
                n_ue.limit = r_item.value;
                exec_u_we  = 1'b1;
            end
            OP_SET_GLIMIT: begin
                n_ge.limit = r_item.value;
                exec_g_we  = 1'b1;
            end
            OP_CLEAR_USAGE: begin
                n_total_usage = '0;
            end
            OP_SET_UUSAGE: begin
                n_ue.usage = r_item.value;
                exec_u_we  = 1'b1;
            end
            OP_SET_GUSAGE: begin
                n_ge.usage = r_item.value;
                exec_g_we  = 1'b1;
            end
            OP_SET_TUSAGE: begin
                n_total_usage = r_item.value;
            end
            OP_READ_USER: begin
                n_out_data.usage     = u_rd_data.usage;
                n_out_data.limit_out = u_rd_data.limit;
            end
            OP_READ_GROUP: begin
                n_out_data.usage     = g_rd_data.usage;
                n_out_data.limit_out = g_rd_data.limit;
            end
            OP_READ_TOTAL: begin
                n_out_data.usage     = r_total_usage;
                n_out_data.limit_out = r_total_limit;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (&r_cnt[ID_BITS-1:0]) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = (t_op'(r_item.op) == OP_CLEAR_USAGE) ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (r_cnt[ID_BITS] && !r_wr_pend) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // State outputs: handshake and RAM ports
    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        rd_en      = 1'b0;
        u_rd_addr  = to_index(i_in_data.user_id);
        g_rd_addr  = to_index(i_in_data.group_id);
        u_we       = 1'b0;
        g_we       = 1'b0;
        u_wr_addr  = r_cnt[ID_BITS-1:0];
        g_wr_addr  = r_cnt[ID_BITS-1:0];
        u_wr_data  = '0;
        g_wr_data  = '0;
        case (r_state)
            ST_INIT: begin
                u_we = 1'b1;
                g_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = i_in_valid;
            end
            ST_EXEC: begin
                out_load  = out_free;
                u_we      = out_free && exec_u_we;
                g_we      = out_free && exec_g_we;
                u_wr_addr = to_index(r_item.user_id);
                g_wr_addr = to_index(r_item.group_id);
                u_wr_data = n_ue;
                g_wr_data = n_ge;
            end
            ST_CLEAR: begin
                rd_en           = !r_cnt[ID_BITS];
                u_rd_addr       = r_cnt[ID_BITS-1:0];
                g_rd_addr       = r_cnt[ID_BITS-1:0];
                u_we            = r_wr_pend;
                g_we            = r_wr_pend;
                u_wr_addr       = r_wr_addr;
                g_wr_addr       = r_wr_addr;
                u_wr_data.limit = u_rd_data.limit;
                g_wr_data.limit = g_rd_data.limit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_INIT;
            r_cnt         <= '0;
            r_wr_pend     <= 1'b0;
            r_total_usage <= '0;
            r_total_limit <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= (r_state == ST_CLEAR) && !r_cnt[ID_BITS];
            if (r_state == ST_INIT || (r_state == ST_CLEAR && !r_cnt[ID_BITS])) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == ST_EXEC) begin
                r_cnt <= '0;
            end
            if (out_load) begin
                r_total_usage <= n_total_usage;
            end
            if (i_cfg_wr_en) begin
                r_total_limit <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out_data <= n_out_data;
        end
        r_wr_addr <= r_cnt[ID_BITS-1:0];
    end

    ugqa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_user_ram (
        .i_clk     (i_clk),
        .i_wr_en   (u_we),
        .i_wr_addr (u_wr_addr),
        .i_wr_data (u_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (u_rd_addr),
        .o_rd_data (u_rd_data)
    );

    ugqa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_group_ram (
        .i_clk     (i_clk),
        .i_wr_en   (g_we),
        .i_wr_addr (g_wr_addr),
        .i_wr_data (g_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (g_rd_addr),
        .o_rd_data (g_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
